### hdl/sqf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqf_pkg
// Shared constants and types for the single-precision square root lane.
// ----------------------------------------------------------------------------
package sqf_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned RootBits  = 25;  // 24 mantissa bits plus round bit
  localparam int unsigned RadWidth  = 50;  // radicand width
  localparam int unsigned RemWidth  = 27;  // remainder width
  localparam logic [31:0] QnanCanon = 32'h7FC0_0000;
  localparam logic [31:0] QuietBit  = 32'h0040_0000;

  // Per-word control carried alongside the digit recurrence
  typedef struct packed {
    logic        valid;
    logic        special;   // result fixed before recurrence
    logic [31:0] spec_bits;
    logic        spec_inv;
    logic [7:0]  exp_out;   // biased result exponent before rounding carry
  } sqf_ctl_t;

  // Leading zero count of a 23-bit fraction (denormal normalization)
  function automatic logic [4:0] sqf_lzc23(input logic [22:0] f);
    logic [4:0] n;
    logic       found;
    n = 5'd23;
    found = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found && f[i]) begin
        n = 5'(22 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

### hdl/sqf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqf_cell
// One step of the restoring square root recurrence: consumes two radicand
// bits, produces one root bit, registers everything for the next cell.
// ----------------------------------------------------------------------------
module sqf_cell (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 en,
  input  wire sqf_pkg::sqf_ctl_t                    ctl_in,
  input  wire logic [sqf_pkg::RadWidth-1:0]         rad_in,
  input  wire logic [sqf_pkg::RemWidth-1:0]         rem_in,
  input  wire logic [sqf_pkg::RootBits-1:0]         root_in,
  output sqf_pkg::sqf_ctl_t                         ctl_out,
  output logic [sqf_pkg::RadWidth-1:0]              rad_out,
  output logic [sqf_pkg::RemWidth-1:0]              rem_out,
  output logic [sqf_pkg::RootBits-1:0]              root_out
);
  import sqf_pkg::*;

  logic [RemWidth-1:0] rem_sh;
  logic [RemWidth-1:0] trial;
  logic                take;
  logic [RemWidth-1:0] rem_next;
  logic [RootBits-1:0] root_next;

  always_comb begin
    rem_sh    = {rem_in[RemWidth-3:0], rad_in[RadWidth-1:RadWidth-2]};
    trial     = {root_in[RemWidth-3:0], 2'b01};
    take      = (rem_sh >= trial);
    rem_next  = take ? (rem_sh - trial) : rem_sh;
    root_next = {root_in[RootBits-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.special   <= ctl_in.special;
      ctl_out.spec_bits <= ctl_in.spec_bits;
      ctl_out.spec_inv  <= ctl_in.spec_inv;
      ctl_out.exp_out   <= ctl_in.exp_out;
      rad_out           <= {rad_in[RadWidth-3:0], 2'b00};
      rem_out           <= rem_next;
      root_out          <= root_next;
    end
  end

endmodule
`default_nettype wire

### hdl/sqrt_float32_lane_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqrt_float32_lane_core
// IEEE 754 single-precision square root, round to nearest even.
// ----------------------------------------------------------------------------
// Accepts one word per cycle when not stalled and returns one result word per
// input, in order. The accepting edge loads the unpack stage, then a chain of 25
// recurrence cells (one root bit each) and one rounding/output register
// follow. The whole chain advances together; it stalls only when the
// output register is full and not being taken.
module sqrt_float32_lane_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        operand_bits_valid,
  output logic             operand_bits_ready,
  input  wire logic [31:0] operand_bits,
  output logic             root_valid,
  input  wire logic        root_ready,
  output logic [31:0]      root_bits,
  output logic             invalid_flag
);
  import sqf_pkg::*;

  localparam int unsigned NCells = RootBits;

  logic en;
  assign en = !root_valid || root_ready;
  assign operand_bits_ready = en;

  // ---------------- unpack ----------------
  logic        sgn;
  logic [7:0]  expf;
  logic [22:0] frac;
  logic [4:0]  lz;
  logic [23:0] sig;
  logic [9:0]  e_unb;   // e + 127 + 32, biased positive
  logic [24:0] sig2;
  logic [9:0]  e_even;
  sqf_ctl_t    ctl0_next;

  always_comb begin
    sgn  = operand_bits[31];
    expf = operand_bits[30:23];
    frac = operand_bits[22:0];
    lz   = sqf_lzc23(frac);
    if (expf == 8'd0) begin
      sig   = {1'b0, frac} << (lz + 5'd1);
      e_unb = 10'd32 - 10'(lz);  // e = -127 - lz, offset 159
    end else begin
      sig   = {1'b1, frac};
      e_unb = 10'(expf) + 10'd32;
    end
    // e_unb = e + 159; e odd iff e_unb even
    if (!e_unb[0]) begin
      sig2   = {sig, 1'b0};
      e_even = e_unb - 10'd1;
    end else begin
      sig2   = {1'b0, sig};
      e_even = e_unb;
    end
    ctl0_next.valid     = operand_bits_valid;
    ctl0_next.special   = 1'b1;
    ctl0_next.spec_inv  = 1'b0;
    ctl0_next.spec_bits = operand_bits;
    // (e+159-... ) : eo+127 = (e_even-159)/2+127 = (e_even-159+254)/2
    ctl0_next.exp_out   = 8'((e_even + 10'd95) >> 1);
    if (expf == 8'hFF && frac != 23'd0) begin
      ctl0_next.spec_bits = operand_bits | QuietBit;
    end else if (operand_bits[30:0] == 31'd0) begin
      ctl0_next.spec_bits = operand_bits;
    end else if (sgn) begin
      ctl0_next.spec_bits = QnanCanon;
      ctl0_next.spec_inv  = 1'b1;
    end else if (expf == 8'hFF) begin
      ctl0_next.spec_bits = operand_bits;
    end else begin
      ctl0_next.special = 1'b0;
    end
  end

  sqf_ctl_t            ctl [NCells+1];
  logic [RadWidth-1:0] rad [NCells+1];
  logic [RemWidth-1:0] rem [NCells+1];
  logic [RootBits-1:0] rt  [NCells+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else if (en) begin
      ctl[0].valid <= ctl0_next.valid;
    end
    if (en) begin
      ctl[0].special   <= ctl0_next.special;
      ctl[0].spec_bits <= ctl0_next.spec_bits;
      ctl[0].spec_inv  <= ctl0_next.spec_inv;
      ctl[0].exp_out   <= ctl0_next.exp_out;
      rad[0]           <= {sig2, 25'd0};
      rem[0]           <= '0;
      rt[0]            <= '0;
    end
  end

  for (genvar i = 0; i < NCells; i++) begin : g_cell
    sqf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (ctl[i]),
      .rad_in   (rad[i]),
      .rem_in   (rem[i]),
      .root_in  (rt[i]),
      .ctl_out  (ctl[i+1]),
      .rad_out  (rad[i+1]),
      .rem_out  (rem[i+1]),
      .root_out (rt[i+1])
    );
  end

  // ---------------- round and pack ----------------
  sqf_ctl_t            ct;
  logic [RootBits-1:0] q;
  logic                sticky;
  logic [24:0]         mant;
  logic [7:0]          eo;
  logic [31:0]         res_next;

  always_comb begin
    ct     = ctl[NCells];
    q      = rt[NCells];
    sticky = (rem[NCells] != '0);
    mant   = {1'b0, q[RootBits-1:1]};
    eo     = ct.exp_out;
    if (q[0] && (sticky || mant[0])) begin
      mant = mant + 25'd1;
    end
    // carry out of 24 bits: mantissa becomes 1.0, bump exponent
    if (mant[24]) begin
      eo = eo + 8'd1;
    end
    res_next = ct.special ? ct.spec_bits : {1'b0, eo, mant[22:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (en) begin
      root_valid <= ct.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_bits    <= res_next;
      invalid_flag <= ct.special & ct.spec_inv;
    end
  end

endmodule
`default_nettype wire

### verif/sqrt_float32_lane_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrt_float32_lane_checker
// Watches both channels of the square root lane, predicts each root word and
// compares results in order against the predicted queue.
// ----------------------------------------------------------------------------
module sqrt_float32_lane_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        operand_bits_valid,
  input  logic        operand_bits_ready,
  input  logic [31:0] operand_bits,
  input  logic        root_valid,
  input  logic        root_ready,
  input  logic [31:0] root_bits,
  input  logic        invalid_flag,
  output int          fail_count,
  output int          pending_count
);
  import sqf_pkg::*;

  typedef struct packed {
    logic [31:0] bits;
    logic        inv;
  } root_word_t;

  root_word_t pending_roots[$];

  assign pending_count = pending_roots.size();

  function automatic root_word_t predict_root(input logic [31:0] b);
    root_word_t r;
    logic [7:0]  ef;
    logic [22:0] fr;
    int          e;
    int          eo;
    logic [49:0] rad;
    logic [26:0] rem;
    logic [26:0] trial;
    logic [24:0] q;
    logic [24:0] mant;
    logic        sticky;
    ef = b[30:23];
    fr = b[22:0];
    r.inv = 1'b0;
    if (ef == 8'hFF && fr != 0) begin
      r.bits = b | QuietBit;
    end else if (b[30:0] == 0) begin
      r.bits = b;
    end else if (b[31]) begin
      r.bits = QnanCanon;
      r.inv = 1'b1;
    end else if (ef == 8'hFF) begin
      r.bits = b;
    end else begin
      rad = '0;
      if (ef == 0) begin
        e = -126;
        rad[23:0] = {1'b0, fr};
        while (!rad[23]) begin
          rad = rad << 1;
          e--;
        end
      end else begin
        e = int'(ef) - 127;
        rad[23:0] = {1'b1, fr};
      end
      if (e % 2 != 0) begin
        rad = rad << 1;
        e--;
      end
      rad = rad << 25;
      rem = '0;
      q = '0;
      for (int i = 24; i >= 0; i--) begin
        rem = {rem[24:0], rad[2*i+1 -: 2]};
        trial = {q, 2'b01};
        if (rem >= trial) begin
          rem = rem - trial;
          q = {q[23:0], 1'b1};
        end else begin
          q = {q[23:0], 1'b0};
        end
      end
      sticky = (rem != 0);
      mant = q >> 1;
      eo = e / 2;
      if (q[0] && (sticky || mant[0])) begin
        mant++;
        if (mant[24]) begin
          mant = mant >> 1;
          eo++;
        end
      end
      r.bits = {1'b0, 8'(eo + 127), mant[22:0]};
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] root %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    root_word_t w;
    if (!rst) begin
      if (operand_bits_valid && operand_bits_ready)
        pending_roots.push_back(predict_root(operand_bits));
      if (root_valid && root_ready) begin
        if (pending_roots.size() == 0) begin
          report_mismatch("unexpected word", root_bits, '0);
        end else begin
          w = pending_roots.pop_front();
          if (root_bits !== w.bits) report_mismatch("bits", root_bits, w.bits);
          if (invalid_flag !== w.inv)
            report_mismatch("invalid", {31'd0, invalid_flag}, {31'd0, w.inv});
        end
      end
    end
  end
endmodule

### verif/sqrt_float32_lane_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrt_float32_lane_core_tb
// Drives directed and random single-precision operands through the square
// root lane with random stalls on both sides; the checker scores results.
// ----------------------------------------------------------------------------
module sqrt_float32_lane_core_tb;
  localparam int Latency = 27;
  localparam int CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        operand_bits_valid = 1'b0;
  logic        operand_bits_ready;
  logic [31:0] operand_bits = '0;
  logic        root_valid;
  logic        root_ready = 1'b0;
  logic [31:0] root_bits;
  logic        invalid_flag;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  bit          sink_hold = 1'b0;
  bit          no_idle = 1'b0;

  always #5 clk = ~clk;

  sqrt_float32_lane_core i_dut (
    .clk, .rst, .operand_bits_valid, .operand_bits_ready, .operand_bits,
    .root_valid, .root_ready, .root_bits, .invalid_flag
  );

  sqrt_float32_lane_checker i_checker (
    .clk, .rst, .operand_bits_valid, .operand_bits_ready, .operand_bits,
    .root_valid, .root_ready, .root_bits, .invalid_flag, .fail_count, .pending_count
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rst) root_ready <= 1'b0;
    else root_ready <= !sink_hold && (no_idle || $urandom_range(99) >= 32);
  end

  // valid stays up between back-to-back words; it drops only on an idle cycle
  task automatic send_word(input logic [31:0] w);
    while (!no_idle && $urandom_range(99) < 32) begin
      operand_bits_valid <= 1'b0;
      @(posedge clk);
    end
    operand_bits_valid <= 1'b1;
    operand_bits <= w;
    do @(posedge clk); while (!operand_bits_ready);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(7))
      0: w[30:23] = 8'h00;
      1: w[30:23] = 8'hFF;
      2: w[30:23] = 8'h00 + 8'($urandom_range(1));
      3: w[31] = 1'b0;
      4: w[22:0] = $urandom_range(1) ? 23'h7FFFFF : 23'($urandom_range(3));
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    logic [31:0] directed[$];
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'h7F80_0001, 32'hFFA5_5555, 32'h7FFF_FFFF,
                 32'h3F80_0000, 32'h4080_0000, 32'h4000_0000, 32'hBF80_0000,
                 32'h0000_0001, 32'h007F_FFFF, 32'h0040_0000, 32'h0080_0000,
                 32'h7F7F_FFFF, 32'h3F7F_FFFF, 32'h8000_0001, 32'h3F80_0001,
                 32'h4010_0000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_word(directed[i]);
    // fill the pipe while the receiver holds off
    fork
      begin
        sink_hold = 1'b1;
        repeat (120) @(posedge clk);
        sink_hold = 1'b0;
      end
      for (int i = 0; i < 60; i++) send_word(random_operand());
    join
    operand_bits_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    @(posedge clk);
    no_idle = 1'b1;
    for (int i = 0; i < 200; i++) send_word(random_operand());
    no_idle = 1'b0;
    for (int i = 0; i < 740; i++) send_word(random_operand());
    operand_bits_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (Latency + 5) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
